// ----- design/bdpp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdpp_pkg
// Shared types, codes and sizes for the bus decoder and its parallel port.
// ----------------------------------------------------------------------------
package bdpp_pkg;

    // Memory sizes, held as address widths so that indexing is a bit-select
    localparam int ROM_AW    = 13;
    localparam int RAM_AW    = 10;
    localparam int CAL_AW    = 8;
    localparam int ROM_DEPTH = 1 << ROM_AW;
    localparam int RAM_DEPTH = 1 << RAM_AW;
    localparam int CAL_DEPTH = 1 << CAL_AW;
    localparam int CAL_W     = 4;

    // Bus actions
    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_PRELOAD = 2'd2;

    // Address map
    localparam logic [15:0] MAP_LOW_MASK = 16'hC000;
    localparam int          MAP_PORT_BIT = 15;
    localparam logic [2:0]  SEL_EXTI     = 3'd4;
    localparam logic [2:0]  SEL_CAL      = 3'd5;
    localparam logic [2:0]  SEL_RAM      = 3'd6;
    localparam logic [2:0]  SEL_EXTH     = 3'd7;

    // Port register select and control word layout
    localparam logic [1:0] PORT_A    = 2'd0;
    localparam logic [1:0] PORT_B    = 2'd1;
    localparam logic [1:0] PORT_C    = 2'd2;
    localparam logic [1:0] PORT_CTRL = 2'd3;
    localparam int         CW_MODE_SET  = 7;
    localparam int         CW_A_IN      = 4;
    localparam int         CW_CU_IN     = 3;
    localparam int         CW_B_IN      = 1;
    localparam int         CW_CL_IN     = 0;
    localparam logic [7:0] CW_MODE_MASK = 8'h64;

    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [3:0] CAL_HIGH  = 4'hF;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNMAPPED  = 3'd1,
        ST_ROM_WRITE = 3'd2,
        ST_BAD_MODE  = 3'd3,
        ST_BSR       = 3'd4,
        ST_CTRL_READ = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        R_NONE, R_ROM, R_RAM, R_EXTI, R_EXTH, R_CAL, R_PORT
    } t_region;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [7:0]  pins_a;
        logic [7:0]  pins_b;
        logic [7:0]  pins_c;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] status;
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        logic [7:0] drive_c;
        logic       ports_updated;
    } t_result;

    // Request from the decoder to the parallel port
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [1:0] sel;
        logic [7:0] wdata;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
        logic [7:0] pins_c;
    } t_ppi_req;

    // Answer of the parallel port; drive bytes are after the access
    typedef struct packed {
        logic [7:0] rd_data;
        t_status    status;
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        logic [7:0] drive_c;
        logic       updated;
    } t_ppi_rsp;

    // Region of a bus address, from A15..A11
    function automatic t_region decode_region(input logic [15:0] addr);
        t_region r;
        r = R_NONE;
        if ((addr & MAP_LOW_MASK) == 16'h0000) begin
            case (addr[13:11])
                SEL_EXTI: r = R_EXTI;
                SEL_CAL:  r = R_CAL;
                SEL_RAM:  r = R_RAM;
                SEL_EXTH: r = R_EXTH;
                default:  r = R_ROM;
            endcase
        end else if (addr[MAP_PORT_BIT]) begin
            r = R_PORT;
        end
        return r;
    endfunction

endpackage

// ----- design/bdpp_ppi.sv -----
// ----------------------------------------------------------------------------
// bdpp_ppi
// Mode-0 parallel port: direction and latch registers for ports A, B and C,
// control word handling and the pin/latch mix on reads.
// ----------------------------------------------------------------------------
module bdpp_ppi
    import bdpp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ppi_req i_req,
    output t_ppi_rsp o_rsp
);

    logic [7:0] r_dir_a, r_dir_b, r_dir_c;
    logic [7:0] r_latch_a, r_latch_b, r_latch_c;
    logic [7:0] n_dir_a, n_dir_b, n_dir_c;
    logic [7:0] n_latch_a, n_latch_b, n_latch_c;
    logic [7:0] sel_dir, sel_latch, sel_pins;

    // Selected port for reads
    always_comb begin
        case (i_req.sel)
            PORT_A: begin
                sel_dir = r_dir_a; sel_latch = r_latch_a; sel_pins = i_req.pins_a;
            end
            PORT_B: begin
                sel_dir = r_dir_b; sel_latch = r_latch_b; sel_pins = i_req.pins_b;
            end
            PORT_C: begin
                sel_dir = r_dir_c; sel_latch = r_latch_c; sel_pins = i_req.pins_c;
            end
            default: begin
                sel_dir = '0; sel_latch = '0; sel_pins = '0;
            end
        endcase
    end

    // Access decode and next register values
    always_comb begin
        n_dir_a   = r_dir_a;
        n_dir_b   = r_dir_b;
        n_dir_c   = r_dir_c;
        n_latch_a = r_latch_a;
        n_latch_b = r_latch_b;
        n_latch_c = r_latch_c;
        o_rsp.rd_data = BYTE_ONES;
        o_rsp.status  = ST_OK;
        o_rsp.updated = 1'b0;

        if (i_req.rd_en) begin
            if (i_req.sel == PORT_CTRL) begin
                o_rsp.status = ST_CTRL_READ;
            end else begin
                o_rsp.rd_data = (sel_pins & ~sel_dir) | (sel_latch & sel_dir);
            end
        end

        if (i_req.wr_en) begin
            case (i_req.sel)
                PORT_A: begin
                    n_latch_a = i_req.wdata; o_rsp.updated = 1'b1;
                end
                PORT_B: begin
                    n_latch_b = i_req.wdata; o_rsp.updated = 1'b1;
                end
                PORT_C: begin
                    n_latch_c = i_req.wdata; o_rsp.updated = 1'b1;
                end
                default: begin
                    // control word: only mode 0 set is taken
                    if (!i_req.wdata[CW_MODE_SET]) begin
                        o_rsp.status = ST_BSR;
                    end else if ((i_req.wdata & CW_MODE_MASK) != 8'h00) begin
                        o_rsp.status = ST_BAD_MODE;
                    end else begin
                        n_dir_a = i_req.wdata[CW_A_IN] ? 8'h00 : BYTE_ONES;
                        n_dir_b = i_req.wdata[CW_B_IN] ? 8'h00 : BYTE_ONES;
                        n_dir_c = {i_req.wdata[CW_CU_IN] ? 4'h0 : 4'hF,
                                   i_req.wdata[CW_CL_IN] ? 4'h0 : 4'hF};
                        n_latch_a = '0;
                        n_latch_b = '0;
                        n_latch_c = '0;
                        o_rsp.updated = 1'b1;
                    end
                end
            endcase
        end

        o_rsp.drive_a = n_latch_a & n_dir_a;
        o_rsp.drive_b = n_latch_b & n_dir_b;
        o_rsp.drive_c = n_latch_c & n_dir_c;
    end

    // Port registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_a   <= '0;
            r_dir_b   <= '0;
            r_dir_c   <= '0;
            r_latch_a <= '0;
            r_latch_b <= '0;
            r_latch_c <= '0;
        end else begin
            r_dir_a   <= n_dir_a;
            r_dir_b   <= n_dir_b;
            r_dir_c   <= n_dir_c;
            r_latch_a <= n_latch_a;
            r_latch_b <= n_latch_b;
            r_latch_c <= n_latch_c;
        end
    end

endmodule

// ----- design/bus_decode_with_parallel_port.sv -----
// ----------------------------------------------------------------------------
// bus_decode_with_parallel_port
// Bus decoder over ROM, work RAM, calibration RAM and a mode-0 parallel port.
// ----------------------------------------------------------------------------
// One bus access is taken when start is high and busy is low. The memories
// are read at that edge; in the next cycle the access is completed and
// written back, and its result is shown on o_result for exactly one cycle
// under o_result_valid, registered from that completion cycle. busy is high
// in the completion cycle, so a new access is not taken until the last one
// has completed, as the synchronous memories are read, then written back.
// The receiver cannot stall results. After reset the calibration RAM is
// cleared one entry a cycle over its CAL_DEPTH entries, with busy held high.
// ----------------------------------------------------------------------------
module bus_decode_with_parallel_port
    import bdpp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_in_item i_item,
    output logic     busy,
    output logic     o_result_valid,
    output t_result  o_result
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state              r_state, n_state;
    logic [CAL_AW-1:0]   r_clr_idx, n_clr_idx;
    t_in_item            r_item, n_item;
    logic                r_valid, n_valid;
    t_result             r_result, n_result;

    logic [7:0]       r_rom_mem [ROM_DEPTH];
    logic [7:0]       r_ram_mem [RAM_DEPTH];
    logic [CAL_W-1:0] r_cal_mem [CAL_DEPTH];
    logic [7:0]       r_rom_q;
    logic [7:0]       r_ram_q;
    logic [CAL_W-1:0] r_cal_q;

    logic     accept, is_exec, is_read, is_write;
    logic     rom_we, ram_we, cal_we;
    t_region  region;
    t_ppi_req ppi_req;
    t_ppi_rsp ppi_rsp;
    t_result  exec_res;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign is_exec = (r_state == S_EXEC);
    assign region  = decode_region(r_item.bus_address);
    assign is_read  = (r_item.action == ACT_READ);
    assign is_write = (r_item.action == ACT_WRITE);

    assign rom_we = is_exec && (r_item.action == ACT_PRELOAD);
    assign ram_we = is_exec && is_write && (region == R_RAM);
    assign cal_we = is_exec && is_write && (region == R_CAL);

    // ROM image: preload write-back, read at accept
    always_ff @(posedge i_clk) begin
        if (rom_we) begin
            r_rom_mem[r_item.bus_address[ROM_AW-1:0]] <= r_item.write_data;
        end
        if (accept) begin
            r_rom_q <= r_rom_mem[i_item.bus_address[ROM_AW-1:0]];
        end
    end

    // Work RAM
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram_mem[r_item.bus_address[RAM_AW-1:0]] <= r_item.write_data;
        end
        if (accept) begin
            r_ram_q <= r_ram_mem[i_item.bus_address[RAM_AW-1:0]];
        end
    end

    // Calibration RAM, swept to zero after reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_cal_mem[r_clr_idx] <= '0;
        end else if (cal_we) begin
            r_cal_mem[r_item.bus_address[CAL_AW-1:0]] <= r_item.write_data[CAL_W-1:0];
        end
        if (accept) begin
            r_cal_q <= r_cal_mem[i_item.bus_address[CAL_AW-1:0]];
        end
    end

    // Parallel port
    always_comb begin
        ppi_req.rd_en  = is_exec && is_read && (region == R_PORT);
        ppi_req.wr_en  = is_exec && is_write && (region == R_PORT);
        ppi_req.sel    = r_item.bus_address[1:0];
        ppi_req.wdata  = r_item.write_data;
        ppi_req.pins_a = r_item.pins_a;
        ppi_req.pins_b = r_item.pins_b;
        ppi_req.pins_c = r_item.pins_c;
    end

    bdpp_ppi u_ppi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ppi_req),
        .o_rsp   (ppi_rsp)
    );

    // Result of the access in progress
    always_comb begin
        exec_res.read_data     = BYTE_ONES;
        exec_res.status        = ST_OK;
        exec_res.drive_a       = ppi_rsp.drive_a;
        exec_res.drive_b       = ppi_rsp.drive_b;
        exec_res.drive_c       = ppi_rsp.drive_c;
        exec_res.ports_updated = ppi_rsp.updated;
        if (is_read) begin
            case (region)
                R_ROM:  exec_res.read_data = r_rom_q;
                R_RAM:  exec_res.read_data = r_ram_q;
                R_CAL:  exec_res.read_data = {CAL_HIGH, r_cal_q};
                R_EXTI: exec_res.read_data = BYTE_ONES;
                R_PORT: begin
                    exec_res.read_data = ppi_rsp.rd_data;
                    exec_res.status    = ppi_rsp.status;
                end
                default: exec_res.status = ST_UNMAPPED;
            endcase
        end else if (is_write) begin
            case (region)
                R_ROM:  exec_res.status = ST_ROM_WRITE;
                R_RAM:  exec_res.status = ST_OK;
                R_CAL:  exec_res.status = ST_OK;
                R_PORT: exec_res.status = ppi_rsp.status;
                default: exec_res.status = ST_UNMAPPED;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_item    = r_item;
        n_valid   = 1'b0;
        n_result  = r_result;
        case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == CAL_AW'(CAL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_valid  = 1'b1;
                n_result = exec_res;
                n_state  = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_valid   <= n_valid;
        end
        r_item   <= n_item;
        r_result <= n_result;
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

    // Checks
    a_result_two_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_result_valid ##1 o_result_valid)
        else $error("result not delivered two cycles after accept");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_update_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.ports_updated) |-> (o_result.status == ST_OK))
        else $error("port update reported with an error status");

    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> busy)
        else $error("access possible before calibration RAM cleared");

endmodule
